[hdl/ugli_pkg.sv]
// Shared types and constants of the uniform grid linear interpolator.
// Used by uniform_grid_linear_interpolator; depends on nothing.
package ugli_pkg;

  localparam int VAL_W    = 32;  // signed Q16.16 value
  localparam int FRAC_W   = 16;  // fraction bits of Q16.16
  localparam int WGT_W    = 17;  // blend weight, 0 .. 65536
  localparam int SLOT_W   = 6;   // knot_slot field
  localparam int KCNT_W   = 7;   // knots_in_use register
  localparam int IN_W     = 72;  // s_axis_tdata, padded to bytes
  localparam int OUT_W    = 32;  // m_axis_tdata
  localparam int CFG_IDX_W = 2;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KNOTS_IN_USE    = 2'd0,
    REG_LOWER_BOUND     = 2'd1,
    REG_UPPER_BOUND     = 2'd2,
    REG_INVERSE_SPACING = 2'd3
  } cfg_reg_t;

  localparam logic [KCNT_W-1:0] KNOTS_RESET   = 7'd2;
  localparam logic [VAL_W-1:0]  LOWER_RESET   = 32'h0000_0000;
  localparam logic [VAL_W-1:0]  UPPER_RESET   = 32'h0001_0000;
  localparam logic [VAL_W-1:0]  INVSPC_RESET  = 32'h0001_0000;
  localparam logic [WGT_W-1:0]  WGT_FULL      = 17'h1_0000;

endpackage

[hdl/uniform_grid_linear_interpolator.sv]
// Top level of the uniform grid linear interpolator: knot table memory and
// the evaluation pipeline. Depends on ugli_pkg.
//
// Evaluates a piecewise linear function over evenly spaced knots. Each input
// word either writes one knot into the table or evaluates the function at a
// sample point; only evaluations give an output word. The pipeline takes one
// word every cycle unless back pressure stalls it. Its stages, in order:
// bound compare, offset scaling multiply, segment and weight pick, table read
// (two read ports), knot difference, weight multiply, final add into the
// output register. Knot writes and table reads happen in the same stage, so
// they stay in stream order. Each stage holds under back pressure on its own,
// so input words are still taken while a finished result waits, until every
// stage is full. The knot table has no reset; a slot must be written before
// an evaluation reads it.
module uniform_grid_linear_interpolator #(
  parameter int MAX_KNOTS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [ugli_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ugli_pkg::VAL_W-1:0]          cfg_data,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [5:0] knot_slot, [37:6] knot_value, [69:38] sample_point, [71:70] zero
  input  logic [ugli_pkg::IN_W-1:0]           s_axis_tdata,
  // [0] cmd
  input  logic                                s_axis_tuser,
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] interpolated
  output logic [ugli_pkg::OUT_W-1:0]          m_axis_tdata,
  // [0] below_range, [1] above_range
  output logic [1:0]                          m_axis_tuser
);

  localparam int IDX_W = (MAX_KNOTS > 2) ? $clog2(MAX_KNOTS) : 1;
  localparam int CW    = (IDX_W + 1 > ugli_pkg::KCNT_W) ? IDX_W + 1 : ugli_pkg::KCNT_W;
  localparam int VW    = ugli_pkg::VAL_W;
  localparam int WW    = ugli_pkg::WGT_W;
  localparam int PW    = VW + 1 + WW + 1;  // weighted difference product

  // configuration registers
  logic [ugli_pkg::KCNT_W-1:0] knots_in_use;
  logic [VW-1:0]               lower_bound;
  logic [VW-1:0]               upper_bound;
  logic [VW-1:0]               inverse_spacing;

  always_ff @(posedge clk) begin
    if (rst) begin
      knots_in_use    <= ugli_pkg::KNOTS_RESET;
      lower_bound     <= ugli_pkg::LOWER_RESET;
      upper_bound     <= ugli_pkg::UPPER_RESET;
      inverse_spacing <= ugli_pkg::INVSPC_RESET;
    end else if (cfg_we) begin
      unique case (ugli_pkg::cfg_reg_t'(cfg_index))
        ugli_pkg::REG_KNOTS_IN_USE:    knots_in_use    <= cfg_data[ugli_pkg::KCNT_W-1:0];
        ugli_pkg::REG_LOWER_BOUND:     lower_bound     <= cfg_data;
        ugli_pkg::REG_UPPER_BOUND:     upper_bound     <= cfg_data;
        ugli_pkg::REG_INVERSE_SPACING: inverse_spacing <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp knot count to [2, MAX_KNOTS]; last segment index is count - 2
  logic [CW-1:0]    knots_raw;
  logic [CW-1:0]    knots_eff;
  logic [CW-1:0]    last_seg;
  logic [IDX_W-1:0] last_addr;

  always_comb begin
    knots_raw = CW'(knots_in_use);
    if (knots_raw < CW'(2)) begin
      knots_eff = CW'(2);
    end else if (knots_raw > CW'(MAX_KNOTS)) begin
      knots_eff = CW'(MAX_KNOTS);
    end else begin
      knots_eff = knots_raw;
    end
    last_seg  = knots_eff - CW'(2);
    last_addr = last_seg[IDX_W-1:0];
  end

  // stage valids and load enables
  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6, en_out;

  assign en_out        = !m_axis_tvalid || m_axis_tready;
  assign en6           = !v6 || en_out;
  assign en5           = !v5 || en6;
  assign en4           = !v4 || en5;
  assign en3           = !v3 || en4;
  assign en2           = !v2 || en3;
  assign en1           = !v1 || en2;
  assign s_axis_tready = en1;

  // stage 1: offset from lower bound and range tests
  logic [VW-1:0]  in_sample;
  logic [VW:0]    in_offset;
  logic           in_below;
  logic           in_above;

  assign in_sample = s_axis_tdata[69:38];
  assign in_offset = {in_sample[VW-1], in_sample} - {lower_bound[VW-1], lower_bound};
  assign in_below  = in_offset[VW];
  assign in_above  = !in_below && ($signed(in_sample) >= $signed(upper_bound));

  ugli_pkg::cmd_t              cmd1, cmd2, cmd3;
  logic [ugli_pkg::SLOT_W-1:0] slot1, slot2, slot3;
  logic [VW-1:0]               kval1, kval2, kval3;
  logic [VW-1:0]               offset1;
  logic                        below1, below2, below3, below4, below5, below6;
  logic                        above1, above2, above3, above4, above5, above6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      cmd1    <= ugli_pkg::cmd_t'(s_axis_tuser);
      slot1   <= s_axis_tdata[5:0];
      kval1   <= s_axis_tdata[37:6];
      offset1 <= in_offset[VW-1:0];
      below1  <= in_below;
      above1  <= in_above;
    end
  end

  // stage 2: scale offset to segment units, unsigned Q32.32
  logic [2*VW-1:0] scaled2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      cmd2    <= cmd1;
      slot2   <= slot1;
      kval2   <= kval1;
      scaled2 <= offset1 * inverse_spacing;
      below2  <= below1;
      above2  <= above1;
    end
  end

  // stage 3: pick segment and weight, access the knot table
  logic [2*VW-1:0] scaled3;
  logic [IDX_W-1:0] rd_addr;
  logic [WW-1:0]    wgt3;
  logic [CW-1:0]    slot_ext;
  logic             wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      cmd3    <= cmd2;
      slot3   <= slot2;
      kval3   <= kval2;
      scaled3 <= scaled2;
      below3  <= below2;
      above3  <= above2;
    end
  end

  always_comb begin
    // below: first segment, zero weight; above or past the end: last knot
    if (below3) begin
      rd_addr = '0;
      wgt3    = '0;
    end else if (above3 || (scaled3[2*VW-1:VW] > VW'(last_seg))) begin
      rd_addr = last_addr;
      wgt3    = ugli_pkg::WGT_FULL;
    end else begin
      rd_addr = scaled3[VW +: IDX_W];
      wgt3    = {1'b0, scaled3[VW-1 -: ugli_pkg::FRAC_W]};
    end
    slot_ext = CW'(slot3);
    wr_en    = v3 && en4 && (cmd3 == ugli_pkg::CMD_WRITE) && (slot_ext < CW'(MAX_KNOTS));
  end

  logic [VW-1:0] knot_mem [MAX_KNOTS];
  logic [VW-1:0] y0_4, y1_4;
  logic [WW-1:0] wgt4;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      knot_mem[slot_ext[IDX_W-1:0]] <= kval3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      y0_4 <= knot_mem[rd_addr];
      y1_4 <= knot_mem[rd_addr + IDX_W'(1)];
    end
  end

  // knot writes end here
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3 && (cmd3 == ugli_pkg::CMD_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      wgt4   <= wgt3;
      below4 <= below3;
      above4 <= above3;
    end
  end

  // stage 5: knot difference
  logic [VW:0]   diff5;
  logic [VW-1:0] y0_5;
  logic [WW-1:0] wgt5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      diff5  <= {y1_4[VW-1], y1_4} - {y0_4[VW-1], y0_4};
      y0_5   <= y0_4;
      wgt5   <= wgt4;
      below5 <= below4;
      above5 <= above4;
    end
  end

  // stage 6: weighted difference, Q16.16 times Q1.16
  logic signed [PW-1:0] prod6;
  logic [VW-1:0]        y0_6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en6) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      prod6  <= $signed(diff5) * $signed({1'b0, wgt5});
      y0_6   <= y0_5;
      below6 <= below5;
      above6 <= above5;
    end
  end

  // output register: y0 + floor(prod / 2^16); the sum is convex, no overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en_out) begin
      m_axis_tvalid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      m_axis_tdata <= y0_6 + prod6[ugli_pkg::FRAC_W +: VW];
      m_axis_tuser <= {above6, below6};
    end
  end

`ifndef SYNTHESIS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("below and above both set on a result");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (v3 && en4 && (cmd3 == ugli_pkg::CMD_WRITE)) |=> !v4)
    else $error("knot write moved past the table stage");

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    (v4 && wgt4[WW-1]) |-> (wgt4[WW-2:0] == '0))
    else $error("blend weight above one");

  a_stall_holds_table_data: assert property (@(posedge clk) disable iff (rst)
    (v4 && !en5) |=> ($stable(y0_4) && $stable(y1_4)))
    else $error("table read data changed while stalled");
`endif

endmodule

[tb/sv/uniform_grid_linear_interpolator_checker.sv]
// Scoreboard for the uniform grid linear interpolator: watches the config port and
// both streams, predicts every evaluation and compares the output words in order.
// Depends on ugli_pkg.
module uniform_grid_linear_interpolator_checker #(
  parameter int MAX_KNOTS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ugli_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ugli_pkg::VAL_W-1:0]      cfg_data,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [ugli_pkg::IN_W-1:0]       s_tdata,
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [ugli_pkg::OUT_W-1:0]      m_tdata,
  input  logic [1:0]                      m_tuser,
  output int                              mismatches,
  output int                              outstanding
);

  typedef struct packed {
    logic [ugli_pkg::VAL_W-1:0] value;
    logic                       below;
    logic                       above;
  } sample_result_t;

  logic [ugli_pkg::VAL_W-1:0]  knots [MAX_KNOTS];
  logic [ugli_pkg::KCNT_W-1:0] knot_count;
  logic [ugli_pkg::VAL_W-1:0]  lower;
  logic [ugli_pkg::VAL_W-1:0]  upper;
  logic [ugli_pkg::VAL_W-1:0]  inv_spacing;
  sample_result_t              expected_samples [$];
  int                          fail_count = 0;

  function automatic int used_knots();
    int k;
    k = int'(knot_count);
    if (k < 2) k = 2;
    if (k > MAX_KNOTS) k = MAX_KNOTS;
    return k;
  endfunction

  // floor(((1 - w) * y0 + w * y1)) with w in Q1.16, 0 .. 1.0
  function automatic logic [ugli_pkg::VAL_W-1:0] blend_knots(
      logic [ugli_pkg::VAL_W-1:0] y0, logic [ugli_pkg::VAL_W-1:0] y1,
      logic [ugli_pkg::WGT_W-1:0] w);
    longint sum;
    sum = (longint'(ugli_pkg::WGT_FULL) - longint'(w)) * longint'($signed(y0))
          + longint'(w) * longint'($signed(y1));
    sum = sum >>> ugli_pkg::FRAC_W;
    return sum[ugli_pkg::VAL_W-1:0];
  endfunction

  function automatic sample_result_t evaluate_sample(logic [ugli_pkg::VAL_W-1:0] x);
    sample_result_t             r;
    longint                     offset;
    logic [63:0]                prod;
    longint                     seg;
    logic [ugli_pkg::WGT_W-1:0] w;
    int                         k;
    k = used_knots();
    r.below = 1'b0;
    r.above = 1'b0;
    offset = longint'($signed(x)) - longint'($signed(lower));
    if (offset < 0) begin
      r.below = 1'b1;
      r.value = knots[0];
    end else if ($signed(x) >= $signed(upper)) begin
      r.above = 1'b1;
      r.value = knots[k-1];
    end else begin
      prod = offset[31:0] * inv_spacing;
      seg = longint'(prod[63:32]);
      w = {1'b0, prod[31:16]};
      // past the last segment: pin to the end knot
      if (seg > k - 2) begin
        seg = k - 2;
        w = ugli_pkg::WGT_FULL;
      end
      r.value = blend_knots(knots[seg], knots[seg+1], w);
    end
    return r;
  endfunction

  task automatic report_field(string field, logic [ugli_pkg::VAL_W-1:0] want,
                              logic [ugli_pkg::VAL_W-1:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    sample_result_t got;
    sample_result_t want;
    if (rst) begin
      knot_count  = ugli_pkg::KNOTS_RESET;
      lower       = ugli_pkg::LOWER_RESET;
      upper       = ugli_pkg::UPPER_RESET;
      inv_spacing = ugli_pkg::INVSPC_RESET;
      for (int i = 0; i < MAX_KNOTS; i++) knots[i] = '0;
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        case (ugli_pkg::cfg_reg_t'(cfg_index))
          ugli_pkg::REG_KNOTS_IN_USE:    knot_count  = cfg_data[ugli_pkg::KCNT_W-1:0];
          ugli_pkg::REG_LOWER_BOUND:     lower       = cfg_data;
          ugli_pkg::REG_UPPER_BOUND:     upper       = cfg_data;
          ugli_pkg::REG_INVERSE_SPACING: inv_spacing = cfg_data;
          default: ;
        endcase
      end
      // retire the oldest prediction before taking a new word
      if (m_tvalid && m_tready) begin
        got.value = m_tdata;
        got.below = m_tuser[0];
        got.above = m_tuser[1];
        if (expected_samples.size() == 0) begin
          fail_count++;
          $display("%0t: output word with nothing pending, expected none, actual %h/%b",
                   $time, m_tdata, m_tuser);
        end else begin
          want = expected_samples.pop_front();
          if (got.value !== want.value) report_field("interpolated", want.value, got.value);
          if (got.below !== want.below) report_field("below_range", want.below, got.below);
          if (got.above !== want.above) report_field("above_range", want.above, got.above);
        end
      end
      if (s_tvalid && s_tready) begin
        if (ugli_pkg::cmd_t'(s_tuser) == ugli_pkg::CMD_WRITE) begin
          if (int'(s_tdata[ugli_pkg::SLOT_W-1:0]) < MAX_KNOTS)
            knots[s_tdata[ugli_pkg::SLOT_W-1:0]] = s_tdata[ugli_pkg::SLOT_W +: ugli_pkg::VAL_W];
        end else begin
          expected_samples.push_back(
            evaluate_sample(s_tdata[ugli_pkg::SLOT_W+ugli_pkg::VAL_W +: ugli_pkg::VAL_W]));
        end
      end
    end
    mismatches  <= fail_count;
    outstanding <= expected_samples.size();
  end

endmodule

[tb/sv/uniform_grid_linear_interpolator_tb.sv]
// Testbench top of the uniform grid linear interpolator: clock, reset, config
// phases, knot and sample stimulus with idling, watchdog and verdict.
// Depends on ugli_pkg, the block and uniform_grid_linear_interpolator_checker.
module uniform_grid_linear_interpolator_tb;

  typedef logic [ugli_pkg::SLOT_W-1:0] slot_t;

  localparam int MAX_KNOTS     = 64;
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLDOFF_LEN   = 400;
  localparam int PHASE_ITEMS   = 140;
  localparam int PHASE_COUNT   = 12;
  localparam logic [ugli_pkg::VAL_W-1:0] PROBES [8] = '{
    32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h0000_8000,
    32'h0000_FFFF, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000
  };

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [ugli_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ugli_pkg::VAL_W-1:0]      cfg_data = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [ugli_pkg::IN_W-1:0]       s_axis_tdata = '0;
  logic                            s_axis_tuser = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [ugli_pkg::OUT_W-1:0]      m_axis_tdata;
  logic [1:0]                      m_axis_tuser;

  int     mismatches;
  int     outstanding;
  int     send_idle_pct = 0;
  int     stall_pct = 0;
  int     holdoff_requests = 0;
  int     holdoff_served = 0;
  int     holdoff_left = 0;
  int     idle_cycles = 0;
  longint cur_lo = 0;
  longint cur_hi = 65536;
  int     cur_k = 2;

  uniform_grid_linear_interpolator #(
    .MAX_KNOTS (MAX_KNOTS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  uniform_grid_linear_interpolator_checker #(
    .MAX_KNOTS (MAX_KNOTS)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_axis_tvalid),
    .s_tready    (s_axis_tready),
    .s_tdata     (s_axis_tdata),
    .s_tuser     (s_axis_tuser),
    .m_tvalid    (m_axis_tvalid),
    .m_tready    (m_axis_tready),
    .m_tdata     (m_axis_tdata),
    .m_tuser     (m_axis_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // output side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (holdoff_served != holdoff_requests) begin
      holdoff_served <= holdoff_requests;
      holdoff_left   <= HOLDOFF_LEN;
      m_axis_tready  <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left  <= holdoff_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [ugli_pkg::VAL_W-1:0] to_q16(longint v);
    if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
    return v[ugli_pkg::VAL_W-1:0];
  endfunction

  // segments per input unit for k knots over [lo, hi), saturated to 32 bits
  function automatic logic [ugli_pkg::VAL_W-1:0] spacing_for(int k, longint lo, longint hi);
    longint q;
    if (hi <= lo) return $urandom;
    q = (longint'(k - 1) <<< 32) / (hi - lo);
    if (q > 64'sh0_FFFF_FFFF) q = 64'sh0_FFFF_FFFF;
    return q[ugli_pkg::VAL_W-1:0];
  endfunction

  function automatic logic [ugli_pkg::VAL_W-1:0] pick_sample();
    longint          span;
    longint          x;
    longint unsigned r;
    int              sel;
    span = cur_hi - cur_lo;
    sel  = $urandom_range(9);
    r    = {$urandom, $urandom};
    if (sel < 2) begin
      x = longint'($signed($urandom));
    end else if (sel == 2) begin
      x = ($urandom_range(1) ? cur_lo : cur_hi) + int'($urandom_range(2)) - 1;
    end else if (span <= 0) begin
      x = cur_lo + longint'($signed(r[15:0]));
    end else if (sel == 3) begin
      // on or next to a knot
      x = cur_lo + span * int'($urandom_range(cur_k - 1)) / (cur_k - 1)
          + int'($urandom_range(2)) - 1;
    end else begin
      x = cur_lo - span / 8 + longint'(r % longint'(span + span / 4 + 1));
    end
    return to_q16(x);
  endfunction

  task automatic send_word(ugli_pkg::cmd_t cmd, slot_t slot,
                           logic [ugli_pkg::VAL_W-1:0] value,
                           logic [ugli_pkg::VAL_W-1:0] point);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, point, value, slot};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic write_knot(slot_t slot, logic [ugli_pkg::VAL_W-1:0] value);
    send_word(ugli_pkg::CMD_WRITE, slot, value, $urandom);
  endtask

  task automatic eval_point(logic [ugli_pkg::VAL_W-1:0] point);
    send_word(ugli_pkg::CMD_EVAL, slot_t'($urandom), $urandom, point);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    // let the count see the last word taken
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // knot writes may still be in the pipeline
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(ugli_pkg::cfg_reg_t idx, logic [ugli_pkg::VAL_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic set_config(logic [ugli_pkg::VAL_W-1:0] kreg, longint lo, longint hi,
                            logic [ugli_pkg::VAL_W-1:0] inv);
    wait_idle();
    write_reg(ugli_pkg::REG_KNOTS_IN_USE, kreg);
    write_reg(ugli_pkg::REG_LOWER_BOUND, to_q16(lo));
    write_reg(ugli_pkg::REG_UPPER_BOUND, to_q16(hi));
    write_reg(ugli_pkg::REG_INVERSE_SPACING, inv);
    cfg_we <= 1'b0;
    cur_lo = longint'($signed(to_q16(lo)));
    cur_hi = longint'($signed(to_q16(hi)));
    cur_k  = int'(kreg[ugli_pkg::KCNT_W-1:0]);
    if (cur_k < 2) cur_k = 2;
    if (cur_k > MAX_KNOTS) cur_k = MAX_KNOTS;
  endtask

  task automatic run_random(int count);
    logic [ugli_pkg::VAL_W-1:0] value;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) begin
        value = $urandom;
        if ($urandom_range(7) == 0) value = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        write_knot(slot_t'($urandom), value);
      end else begin
        eval_point(pick_sample());
      end
    end
  endtask

  initial begin
    longint lo;
    longint hi;
    longint tmp;
    int     k;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the whole table so no evaluation reads an unwritten slot
    for (int s = 0; s < MAX_KNOTS; s++) write_knot(slot_t'(s), $urandom);

    // extremes on the reset interval [0, 1.0) with two knots
    write_knot(slot_t'(0), 32'h8000_0000);
    write_knot(slot_t'(1), 32'h7FFF_FFFF);
    for (int i = 0; i < 8; i++) eval_point(PROBES[i]);
    write_knot(slot_t'(0), 32'h7FFF_FFFF);
    write_knot(slot_t'(1), 32'h8000_0000);
    for (int i = 2; i < 5; i++) eval_point(PROBES[i]);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: ;
        1: set_config(64, -64'sh8000_0000, 64'sh7FFF_FFFF,
                      spacing_for(64, -64'sh8000_0000, 64'sh7FFF_FFFF));
        // saturating segment: full-scale inverse spacing
        2: set_config(2, -65536, 65536, 32'hFFFF_FFFF);
        3: begin
          lo = longint'($signed($urandom)) >>> 8;
          set_config(0, lo, lo + $urandom_range(1 << 24, 1), 32'h0000_0000);
        end
        // count above the table size, empty interval
        4: begin
          lo = longint'($signed($urandom));
          set_config(($urandom & ~32'h7F) | 32'h7F, lo, lo, $urandom);
        end
        // reversed interval
        5: set_config(17, 1000000, -1000000, $urandom);
        6: set_config(1, -300000, 700000, spacing_for(2, -300000, 700000));
        7: set_config(64, 64'sh7FFF_0000, 64'sh7FFF_FFFF,
                      spacing_for(64, 64'sh7FFF_0000, 64'sh7FFF_FFFF));
        default: begin
          k  = $urandom_range(MAX_KNOTS, 2);
          lo = longint'($signed($urandom));
          if ($urandom_range(1)) begin
            hi = lo + $urandom_range(1 << 20, 1);
          end else begin
            hi = longint'($signed($urandom));
            if (hi < lo) begin
              tmp = lo;
              lo  = hi;
              hi  = tmp;
            end
          end
          set_config(($urandom & ~32'h7F) | k, lo, hi,
                     spacing_for(k, lo, to_q16(hi) == 32'h7FFF_FFFF ? 64'sh7FFF_FFFF : hi)
                     + ($urandom_range(2) == 0 ? $urandom_range(1000) : 0));
        end
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 74; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      // fill the pipeline against a long output hold-off
      if (p == 2) holdoff_requests++;
      run_random(PHASE_ITEMS);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
